// File: hw/rtl/lc3d_pkg.sv
package lc3d_pkg;

	localparam int WordW = 16;
	localparam int RegW  = 3;
	localparam int ImmW  = 6;

	typedef enum logic [4:0] {
		MN_BR    = 5'd0,
		MN_ADD   = 5'd1,
		MN_LD    = 5'd2,
		MN_ST    = 5'd3,
		MN_JSR   = 5'd4,
		MN_JSRR  = 5'd5,
		MN_AND   = 5'd6,
		MN_LDR   = 5'd7,
		MN_STR   = 5'd8,
		MN_RTI   = 5'd9,
		MN_NOT   = 5'd10,
		MN_LDI   = 5'd11,
		MN_STI   = 5'd12,
		MN_JMP   = 5'd13,
		MN_RET   = 5'd14,
		MN_LEA   = 5'd15,
		MN_GETC  = 5'd16,
		MN_OUT   = 5'd17,
		MN_PUTS  = 5'd18,
		MN_IN    = 5'd19,
		MN_PUTSP = 5'd20,
		MN_HALT  = 5'd21
	} mnemonic_t;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic REQ_ORIGIN = 1'b0;
	localparam logic REQ_INSTR  = 1'b1;

	localparam logic [7:0] TRAP_FIRST = 8'h20;
	localparam logic [7:0] TRAP_LAST  = 8'h25;

	localparam logic [RegW-1:0] REG_LINK = 3'd7;

endpackage

// File: hw/rtl/lc3d_req_if.sv
interface lc3d_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] word;

	modport source (output valid, output req_type, output word, input ready);
	modport sink (input valid, input req_type, input word, output ready);
endinterface

// File: hw/rtl/lc3d_res_if.sv
interface lc3d_res_if
	import lc3d_pkg::*;
;
	logic        valid;
	logic        ready;
	mnemonic_t   mnemonic;
	logic [2:0]  cond_flags;
	logic [2:0]  reg_a;
	logic [2:0]  reg_b;
	logic [2:0]  reg_c;
	logic        uses_immediate;
	logic signed [5:0] immediate;
	logic [15:0] target_address;

	modport source (
		output valid, output mnemonic, output cond_flags, output reg_a, output reg_b,
		output reg_c, output uses_immediate, output immediate, output target_address,
		input ready
	);
	modport sink (
		input valid, input mnemonic, input cond_flags, input reg_a, input reg_b,
		input reg_c, input uses_immediate, input immediate, input target_address,
		output ready
	);
endinterface

// File: hw/rtl/lc3_instruction_decoder_unit.sv
// lc3 instruction decoder
// req channel: one beat per word; req_type 0 loads the program counter with
// word and gives no result, req_type 1 decodes word as an instruction after
// incrementing the program counter.
// res channel: one beat per decoded instruction with mnemonic, register
// fields, immediate and pc-relative target (16-bit wrap). reserved opcode 13
// and trap vectors outside 0x20..0x25 give no beat but still count.
// path: an accepted req beat passes the input register, then the result
// register, which offers it as its res beat.
// throughput: one word per cycle while res.ready is high; the decode and the
// 16-bit target add sit between the input register and the result register.
// stall: when res.ready is low the result register holds, the input register
// fills behind it, and then req.ready drops until the result is taken.
// reset: arst_n low clears both valid flags and the program counter to zero.
module lc3_instruction_decoder_unit
	import lc3d_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lc3d_req_if.sink      req,
	lc3d_res_if.source    res
);

	logic              valid_s1;
	logic              req_type_s1;
	logic [WordW-1:0]  word_s1;
	logic [WordW-1:0]  pc_q;

	logic              valid_s2;
	mnemonic_t         mnemonic_s2;
	logic [RegW-1:0]   cond_s2, reg_a_s2, reg_b_s2, reg_c_s2;
	logic              uimm_s2;
	logic [ImmW-1:0]   imm_s2;
	logic [WordW-1:0]  tgt_s2;

	logic              adv_s1;
	logic              emit;
	mnemonic_t         mn;
	logic [RegW-1:0]   cond, ra, rb, rc;
	logic              uimm;
	logic [ImmW-1:0]   imm;
	logic [WordW-1:0]  pc_inc, tgt, off9, off11;
	logic [3:0]        op;
	logic [7:0]        vec;

	assign adv_s1    = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			word_s1     <= req.word;
		end
	end

	assign pc_inc = pc_q + 16'd1;
	assign op     = word_s1[15:12];
	assign vec    = word_s1[7:0];
	assign off9   = {{7{word_s1[8]}}, word_s1[8:0]};
	assign off11  = {{5{word_s1[10]}}, word_s1[10:0]};

	always_comb begin
		emit = 1'b1;
		mn   = MN_BR;
		cond = '0;
		ra   = '0;
		rb   = '0;
		rc   = '0;
		uimm = 1'b0;
		imm  = '0;
		tgt  = '0;
		case (op)
			OP_BR: begin
				mn   = MN_BR;
				cond = word_s1[11:9];
				tgt  = pc_inc + off9;
			end
			OP_ADD, OP_AND: begin
				mn = (op == OP_ADD) ? MN_ADD : MN_AND;
				ra = word_s1[11:9];
				rb = word_s1[8:6];
				if (word_s1[5]) begin
					uimm = 1'b1;
					imm  = {word_s1[4], word_s1[4:0]};
				end else begin
					rc = word_s1[2:0];
				end
			end
			OP_LD, OP_ST, OP_LDI, OP_STI, OP_LEA: begin
				case (op)
					OP_LD:   mn = MN_LD;
					OP_ST:   mn = MN_ST;
					OP_LDI:  mn = MN_LDI;
					OP_STI:  mn = MN_STI;
					default: mn = MN_LEA;
				endcase
				ra  = word_s1[11:9];
				tgt = pc_inc + off9;
			end
			OP_JSR: begin
				if (word_s1[11]) begin
					mn  = MN_JSR;
					tgt = pc_inc + off11;
				end else begin
					mn = MN_JSRR;
					rb = word_s1[8:6];
				end
			end
			OP_LDR, OP_STR: begin
				mn  = (op == OP_LDR) ? MN_LDR : MN_STR;
				ra  = word_s1[11:9];
				rb  = word_s1[8:6];
				imm = word_s1[5:0];
			end
			OP_RTI: mn = MN_RTI;
			OP_NOT: begin
				mn = MN_NOT;
				ra = word_s1[11:9];
				rb = word_s1[8:6];
			end
			OP_JMP: begin
				mn = (word_s1[8:6] == REG_LINK) ? MN_RET : MN_JMP;
				rb = word_s1[8:6];
			end
			OP_TRAP: begin
				// vectors 0x20..0x25 map in order onto the service codes
				if (vec < TRAP_FIRST || vec > TRAP_LAST) begin
					emit = 1'b0;
				end else begin
					mn = mnemonic_t'(5'(MN_GETC) + 5'(vec[2:0]));
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				pc_q     <= (req_type_s1 == REQ_ORIGIN) ? word_s1 : pc_inc;
				valid_s2 <= (req_type_s1 == REQ_INSTR) && emit;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mnemonic_s2 <= mn;
			cond_s2     <= cond;
			reg_a_s2    <= ra;
			reg_b_s2    <= rb;
			reg_c_s2    <= rc;
			uimm_s2     <= uimm;
			imm_s2      <= imm;
			tgt_s2      <= tgt;
		end
	end

	assign res.valid          = valid_s2;
	assign res.mnemonic       = mnemonic_s2;
	assign res.cond_flags     = cond_s2;
	assign res.reg_a          = reg_a_s2;
	assign res.reg_b          = reg_b_s2;
	assign res.reg_c          = reg_c_s2;
	assign res.uses_immediate = uimm_s2;
	assign res.immediate      = imm_s2;
	assign res.target_address = tgt_s2;

endmodule

// File: hw/rtl/lc3d_checker.sv
module lc3d_checker
	import lc3d_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input mnemonic_t   mnemonic,
	input logic [2:0]  reg_b,
	input logic [2:0]  reg_c,
	input logic        uses_immediate,
	input logic [15:0] target_address
);

	// a stalled result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(mnemonic) && $stable(target_address))
		else $error("result payload changed while stalled");

	a_ret_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && mnemonic == MN_RET |-> reg_b == REG_LINK)
		else $error("ret without link register");

	// immediate mode only for add and and, and it clears the second source
	a_imm_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && uses_immediate |->
			(mnemonic == MN_ADD || mnemonic == MN_AND) && reg_c == 3'd0)
		else $error("immediate flag on wrong instruction");

	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (mnemonic == MN_ADD || mnemonic == MN_AND || mnemonic == MN_NOT
			|| mnemonic == MN_JMP || mnemonic == MN_RET || mnemonic == MN_RTI)
			|-> target_address == 16'd0)
		else $error("target on non pc-relative instruction");

endmodule

bind lc3_instruction_decoder_unit lc3d_checker u_lc3d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.mnemonic       (res.mnemonic),
	.reg_b          (res.reg_b),
	.reg_c          (res.reg_c),
	.uses_immediate (res.uses_immediate),
	.target_address (res.target_address)
);
